FILE: src/gbe_pkg.sv
// Shared types and codes for the gap buffer editor.
`default_nettype none

package gbe_pkg;

	// Operation codes carried by the op field
	typedef enum logic [2:0] {
		OP_INSERT     = 3'd0,
		OP_DEL_LEFT   = 3'd1,
		OP_DEL_RIGHT  = 3'd2,
		OP_MOVE_LEFT  = 3'd3,
		OP_MOVE_RIGHT = 3'd4,
		OP_TO_START   = 3'd5,
		OP_TO_END     = 3'd6,
		OP_READ       = 3'd7
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_NOROOM = 2'd1,
		ST_RANGE  = 2'd2
	} stat_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;    // input item taken this cycle
		logic copy;      // perform one gap copy step
		logic load_out;  // load the output register
	} gbe_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic start_copy;  // current input item needs a gap move by the copy engine
		logic copy_last;   // this copy step is the final one
		logic wr_pend;     // a copy write is still in flight
	} gbe_sts_t;

endpackage

`default_nettype wire

FILE: src/gbe_ctrl.sv
// Controller state machine: handshakes, copy sequencing and result staging.
`default_nettype none

module gbe_ctrl import gbe_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire gbe_sts_t sts,
	output gbe_cmd_t      cmd
);

	typedef enum logic {
		S_IDLE,
		S_COPY
	} state_t;

	state_t state_q;
	logic   res_pend_q;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	// Output register can take a new result when empty or being drained
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && !sts.wr_pend && (!res_pend_q || out_free);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign cmd.accept   = accept;
	assign cmd.copy     = (state_q == S_COPY);
	assign cmd.load_out = res_pend_q && out_free;

	// Hold state, pending result flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && sts.start_copy) begin
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					if (sts.copy_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if ((accept && !sts.start_copy) || (state_q == S_COPY && sts.copy_last)) begin
				res_pend_q <= 1'b1;
			end else if (cmd.load_out) begin
				res_pend_q <= 1'b0;
			end

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_copy_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY && sts.copy_last) |=> (res_pend_q && state_q == S_IDLE))
		else $error("copy end did not stage a result");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");

	a_no_accept_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sts.start_copy) |=> (state_q == S_COPY && !res_pend_q))
		else $error("gap move did not enter copy");

endmodule

`default_nettype wire

FILE: src/gbe_dp.sv
// Datapath: text memory, gap bounds, copy engine and output register.
`default_nettype none

module gbe_dp import gbe_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire gbe_cmd_t   cmd,
	output gbe_sts_t        sts,
	input  wire logic [2:0] op,
	input  wire logic [7:0] data_byte,
	input  wire logic [9:0] amount,
	input  wire logic [9:0] position,
	output logic [1:0]      status,
	output logic [7:0]      read_byte,
	output logic [9:0]      cursor,
	output logic [9:0]      text_size
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = ((AW > 10) ? AW : 10) + 1;

	logic [7:0]    mem [CAPACITY];

	logic [AW-1:0] gap_start_q;
	logic [AW-1:0] gap_end_q;
	logic [AW-1:0] count_q;
	logic          dir_left_q;
	stat_t         op_status_q;
	logic          rd_ok_q;
	logic [7:0]    rd_data_q;
	logic [AW-1:0] wr_addr_s1;
	logic          wr_pend_s1;
	logic [1:0]    out_status_q;
	logic [7:0]    out_byte_q;
	logic [9:0]    out_cursor_q;
	logic [9:0]    out_tlen_q;

	op_t           op_in;
	logic [CW-1:0] gs_w;
	logic [CW-1:0] ge_w;
	logic [CW-1:0] amt_w;
	logic [CW-1:0] pos_w;
	logic [CW-1:0] cap_m1_w;
	logic [CW-1:0] tlen_w;
	logic [CW-1:0] n_w;
	logic [CW-1:0] phys_w;
	logic          left_w;
	logic          is_move;
	logic          move_bad;
	logic          ins_ok;
	logic          dl_bad;
	logic          dr_bad;
	logic          rd_bad;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [7:0]    mem_wd;
	logic          mem_re;
	logic [AW-1:0] mem_ra;

	// Widen operands to a common compare width
	assign op_in    = op_t'(op);
	assign gs_w     = {{(CW-AW){1'b0}}, gap_start_q};
	assign ge_w     = {{(CW-AW){1'b0}}, gap_end_q};
	assign amt_w    = {{(CW-10){1'b0}}, amount};
	assign pos_w    = {{(CW-10){1'b0}}, position};
	assign cap_m1_w = CW'(CAPACITY - 1);
	assign tlen_w   = gs_w + cap_m1_w - ge_w;

	// Select gap move distance and direction
	always_comb begin
		n_w     = amt_w;
		left_w  = 1'b0;
		is_move = 1'b1;
		case (op_in)
			OP_MOVE_LEFT: begin
				left_w = 1'b1;
			end
			OP_MOVE_RIGHT: begin
				left_w = 1'b0;
			end
			OP_TO_START: begin
				n_w    = gs_w;
				left_w = 1'b1;
			end
			OP_TO_END: begin
				n_w = cap_m1_w - ge_w;
			end
			default: begin
				is_move = 1'b0;
			end
		endcase
	end

	// Range checks
	assign move_bad = left_w ? (n_w > gs_w) : ((ge_w + n_w) > cap_m1_w);
	assign ins_ok   = (gap_end_q != gap_start_q);
	assign dl_bad   = (amt_w > gs_w);
	assign dr_bad   = ((ge_w + amt_w) > cap_m1_w);
	assign rd_bad   = (pos_w >= tlen_w);
	assign phys_w   = (pos_w < gs_w) ? pos_w : (pos_w + ge_w - gs_w + CW'(1));

	assign sts.start_copy = is_move && !move_bad && (n_w != '0);
	assign sts.copy_last  = (count_q == AW'(1));
	assign sts.wr_pend    = wr_pend_s1;

	// Update gap bounds on edits and copy steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_start_q <= '0;
			gap_end_q   <= AW'(CAPACITY - 1);
			wr_pend_s1  <= 1'b0;
		end else begin
			wr_pend_s1 <= cmd.copy;
			if (cmd.accept) begin
				case (op_in)
					OP_INSERT: begin
						if (ins_ok) begin
							gap_start_q <= gap_start_q + AW'(1);
						end
					end
					OP_DEL_LEFT: begin
						if (!dl_bad) begin
							gap_start_q <= gap_start_q - amt_w[AW-1:0];
						end
					end
					OP_DEL_RIGHT: begin
						if (!dr_bad) begin
							gap_end_q <= gap_end_q + amt_w[AW-1:0];
						end
					end
					default: begin
					end
				endcase
			end else if (cmd.copy) begin
				if (dir_left_q) begin
					gap_start_q <= gap_start_q - AW'(1);
					gap_end_q   <= gap_end_q - AW'(1);
				end else begin
					gap_start_q <= gap_start_q + AW'(1);
					gap_end_q   <= gap_end_q + AW'(1);
				end
			end
		end
	end

	// Capture item status and copy bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			count_q    <= n_w[AW-1:0];
			dir_left_q <= left_w;
			rd_ok_q    <= (op_in == OP_READ) && !rd_bad;
			case (op_in)
				OP_INSERT:    op_status_q <= ins_ok ? ST_DONE : ST_NOROOM;
				OP_DEL_LEFT:  op_status_q <= dl_bad ? ST_RANGE : ST_DONE;
				OP_DEL_RIGHT: op_status_q <= dr_bad ? ST_RANGE : ST_DONE;
				OP_READ:      op_status_q <= rd_bad ? ST_RANGE : ST_DONE;
				default:      op_status_q <= move_bad ? ST_RANGE : ST_DONE;
			endcase
		end else if (cmd.copy) begin
			count_q    <= count_q - AW'(1);
			wr_addr_s1 <= dir_left_q ? gap_end_q : gap_start_q;
		end
	end

	// Memory port selection: insert or copy write, read or copy source
	assign mem_we = (cmd.accept && op_in == OP_INSERT && ins_ok) || wr_pend_s1;
	assign mem_wa = wr_pend_s1 ? wr_addr_s1 : gap_start_q;
	assign mem_wd = wr_pend_s1 ? rd_data_q : data_byte;
	assign mem_re = (cmd.accept && op_in == OP_READ && !rd_bad) || cmd.copy;
	assign mem_ra = cmd.copy ? (dir_left_q ? (gap_start_q - AW'(1)) : (gap_end_q + AW'(1)))
	                         : phys_w[AW-1:0];

	// Text memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= op_status_q;
			out_byte_q   <= rd_ok_q ? rd_data_q : 8'd0;
			out_cursor_q <= gs_w[9:0];
			out_tlen_q   <= tlen_w[9:0];
		end
	end

	assign status    = out_status_q;
	assign read_byte = out_byte_q;
	assign cursor    = out_cursor_q;
	assign text_size = out_tlen_q;

	a_gap_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		gap_end_q >= gap_start_q)
		else $error("gap bounds crossed");

	a_wr_port: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_s1 |-> !cmd.accept)
		else $error("item accepted while copy write in flight");

	a_copy_src: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.copy && dir_left_q) |-> (gap_start_q != '0))
		else $error("left copy past text start");

endmodule

`default_nettype wire

FILE: src/gap_buffer_editor.sv
// Top level of the gap buffer text editor block.
//
// One input item is one edit operation (insert, delete left/right, move gap
// left/right, move to start/end, read). Every item yields exactly one result
// item with a status, the byte read, the cursor and the text length.
// Both channels use valid/ready; an item moves when valid and ready are high.
// Inserts, deletes, reads, zero-length and out-of-range moves skip the copy
// engine: the result is staged in a pending flag, then loaded into the output
// register, and the next item can be taken every cycle while the output keeps
// draining. A gap move over n bytes runs the copy engine one byte per cycle
// through the single memory write port; no new item is taken until the last
// copy write has completed, and its result is staged when the copy ends.
// A finished result waits in the output register; one more item can be taken
// meanwhile, after which in_ready stays low until out_ready frees the register.
// Reset clears the gap bounds to an empty text with the cursor at zero; the
// text memory is not cleared and needs no clearing pass.
`default_nettype none

module gap_buffer_editor import gbe_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] op,
	input  wire logic [7:0] data_byte,
	input  wire logic [9:0] amount,
	input  wire logic [9:0] position,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      status,
	output logic [7:0]      read_byte,
	output logic [9:0]      cursor,
	output logic [9:0]      text_size
);

	gbe_cmd_t cmd;
	gbe_sts_t sts;

	gbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gbe_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.op        (op),
		.data_byte (data_byte),
		.amount    (amount),
		.position  (position),
		.status    (status),
		.read_byte (read_byte),
		.cursor    (cursor),
		.text_size (text_size)
	);

endmodule

`default_nettype wire
